FILE: src/zsrl_pkg.sv
// shared types and constants for the zoned slew rate limiter
package zsrl_pkg;

    localparam int DEFAULT_SAMPLE_BITS = 12;

    localparam int ZONE_STEP_W = 12;
    localparam int LAG_W       = 10;
    localparam int LAG_FRAC    = 8;
    localparam int THRESH_W    = 12;
    localparam int STEP_W      = ZONE_STEP_W + LAG_W - LAG_FRAC;
    localparam int RATE_W      = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_ZONE_STEP  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MID_ZONE_STEP  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_ZONE_STEP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_LAG      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECEL_LAG      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_AGGR_THRESHOLD = 3'd5;

    localparam logic [ZONE_STEP_W-1:0] ZONE_STEP_RESET = 12'd200;
    localparam logic [LAG_W-1:0]       LAG_RESET       = 10'd256;
    localparam logic [THRESH_W-1:0]    THRESH_RESET    = 12'd1000;

    localparam logic [RATE_W-1:0] RATE_MIN  = 16'd8000;
    localparam logic [RATE_W-1:0] RATE_SPAN = 16'd36100;

    typedef struct packed {
        logic [ZONE_STEP_W-1:0] low_zone_step;
        logic [ZONE_STEP_W-1:0] mid_zone_step;
        logic [ZONE_STEP_W-1:0] high_zone_step;
        logic [LAG_W-1:0]       accel_lag;
        logic [LAG_W-1:0]       decel_lag;
        logic [THRESH_W-1:0]    aggressive_threshold;
    } cfg_t;

endpackage

FILE: src/zsrl_cfg.sv
// configuration register file
module zsrl_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [zsrl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [zsrl_pkg::CFG_DATA_W-1:0]    cfg_data,
    output zsrl_pkg::cfg_t                     cfg
);

    zsrl_pkg::cfg_t cfg_reg;
    zsrl_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                zsrl_pkg::CFG_LOW_ZONE_STEP:
                    cfg_next.low_zone_step = cfg_data[zsrl_pkg::ZONE_STEP_W-1:0];
                zsrl_pkg::CFG_MID_ZONE_STEP:
                    cfg_next.mid_zone_step = cfg_data[zsrl_pkg::ZONE_STEP_W-1:0];
                zsrl_pkg::CFG_HIGH_ZONE_STEP:
                    cfg_next.high_zone_step = cfg_data[zsrl_pkg::ZONE_STEP_W-1:0];
                zsrl_pkg::CFG_ACCEL_LAG:
                    cfg_next.accel_lag = cfg_data[zsrl_pkg::LAG_W-1:0];
                zsrl_pkg::CFG_DECEL_LAG:
                    cfg_next.decel_lag = cfg_data[zsrl_pkg::LAG_W-1:0];
                zsrl_pkg::CFG_AGGR_THRESHOLD:
                    cfg_next.aggressive_threshold = cfg_data[zsrl_pkg::THRESH_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_zone_step        <= zsrl_pkg::ZONE_STEP_RESET;
            cfg_reg.mid_zone_step        <= zsrl_pkg::ZONE_STEP_RESET;
            cfg_reg.high_zone_step       <= zsrl_pkg::ZONE_STEP_RESET;
            cfg_reg.accel_lag            <= zsrl_pkg::LAG_RESET;
            cfg_reg.decel_lag            <= zsrl_pkg::LAG_RESET;
            cfg_reg.aggressive_threshold <= zsrl_pkg::THRESH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: src/zsrl_slew.sv
// input register, zoned step selection and smoothed level update
module zsrl_slew
#(
    parameter int SAMPLE_BITS = zsrl_pkg::DEFAULT_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  zsrl_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic                          lvl_valid,
    input  logic                          lvl_ready,
    output logic [SAMPLE_BITS-1:0]        level,
    output logic [zsrl_pkg::STEP_W-1:0]   step
);

    localparam int CW = ((SAMPLE_BITS > zsrl_pkg::STEP_W) ? SAMPLE_BITS
                                                           : zsrl_pkg::STEP_W) + 1;
    localparam int PW = zsrl_pkg::ZONE_STEP_W + zsrl_pkg::LAG_W;

    logic                        s0_valid_reg;
    logic                        s0_valid_next;
    logic [SAMPLE_BITS-1:0]      s0_sample_reg;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [SAMPLE_BITS-1:0]      level_reg;
    logic [SAMPLE_BITS-1:0]      level_next;
    logic [zsrl_pkg::STEP_W-1:0] step_reg;
    logic [zsrl_pkg::STEP_W-1:0] step_next;

    logic                          s0_ready;
    logic                          s1_ready;
    logic                          s0_move;
    logic                          rising;
    logic [SAMPLE_BITS-1:0]        gap;
    logic [zsrl_pkg::ZONE_STEP_W-1:0] base_step;
    logic [zsrl_pkg::LAG_W-1:0]    lag_sel;
    logic [PW-1:0]                 scaled_prod;
    logic                          use_scale;

    assign s1_ready  = !s1_valid_reg || lvl_ready;
    assign s0_ready  = !s0_valid_reg || s1_ready;
    assign s0_move   = s0_valid_reg && s1_ready;
    assign in_ready  = s0_ready;
    assign lvl_valid = s1_valid_reg;
    assign level     = level_reg;
    assign step      = step_reg;

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        if (s0_ready)
        begin
            s0_valid_next = in_valid;
        end
        s1_valid_next = s1_valid_reg;
        if (s0_move)
        begin
            s1_valid_next = 1'b1;
        end
        else if (lvl_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // zone of the current level, lag scaling on a fall or an aggressive rise, then the level step
    always_comb
    begin
        rising = s0_sample_reg > level_reg;
        gap    = rising ? (s0_sample_reg - level_reg) : (level_reg - s0_sample_reg);

        if (level_reg[SAMPLE_BITS-1:SAMPLE_BITS-2] == 2'b00)
        begin
            base_step = cfg.low_zone_step;
        end
        else if (level_reg[SAMPLE_BITS-1:SAMPLE_BITS-2] != 2'b11)
        begin
            base_step = cfg.mid_zone_step;
        end
        else
        begin
            base_step = cfg.high_zone_step;
        end

        lag_sel     = rising ? cfg.accel_lag : cfg.decel_lag;
        scaled_prod = PW'(base_step) * PW'(lag_sel);
        use_scale   = !rising || (CW'(gap) > CW'(cfg.aggressive_threshold));
        step_next   = use_scale ? scaled_prod[PW-1:zsrl_pkg::LAG_FRAC]
                                : zsrl_pkg::STEP_W'(base_step);

        if (CW'(gap) > CW'(step_next))
        begin
            if (rising)
            begin
                level_next = SAMPLE_BITS'(CW'(level_reg) + CW'(step_next));
            end
            else
            begin
                level_next = SAMPLE_BITS'(CW'(level_reg) - CW'(step_next));
            end
        end
        else
        begin
            level_next = s0_sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            level_reg    <= '0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
            if (s0_move)
            begin
                level_reg <= level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            s0_sample_reg <= sample;
        end
        if (s0_move)
        begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: src/zsrl_rate.sv
// playback rate pipeline: level times span, divide by full scale, add minimum rate, output register
module zsrl_rate
#(
    parameter int SAMPLE_BITS = zsrl_pkg::DEFAULT_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          lvl_valid,
    output logic                          lvl_ready,
    input  logic [SAMPLE_BITS-1:0]        level,
    input  logic [zsrl_pkg::STEP_W-1:0]   step,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [SAMPLE_BITS-1:0]        smoothed_value,
    output logic [zsrl_pkg::STEP_W-1:0]   step_used,
    output logic [zsrl_pkg::RATE_W-1:0]   playback_rate
);

    localparam int PW = SAMPLE_BITS + zsrl_pkg::RATE_W;
    localparam int RW = ((SAMPLE_BITS > zsrl_pkg::RATE_W) ? SAMPLE_BITS
                                                           : zsrl_pkg::RATE_W) + 1;
    localparam int QW = zsrl_pkg::RATE_W + 1;
    localparam logic [RW-1:0] FULL_SCALE = RW'((1 << SAMPLE_BITS) - 1);

    logic                        s2_valid_reg;
    logic                        s2_valid_next;
    logic [SAMPLE_BITS-1:0]      s2_level_reg;
    logic [zsrl_pkg::STEP_W-1:0] s2_step_reg;
    logic [PW-1:0]               s2_prod_reg;

    logic                        s3_valid_reg;
    logic                        s3_valid_next;
    logic [SAMPLE_BITS-1:0]      s3_level_reg;
    logic [zsrl_pkg::STEP_W-1:0] s3_step_reg;
    logic [zsrl_pkg::RATE_W-1:0] s3_quot_reg;
    logic [zsrl_pkg::RATE_W-1:0] s3_quot_next;
    logic [RW-1:0]               s3_rem_reg;
    logic [RW-1:0]               s3_rem_next;

    logic                        s4_valid_reg;
    logic                        s4_valid_next;
    logic [SAMPLE_BITS-1:0]      s4_level_reg;
    logic [zsrl_pkg::STEP_W-1:0] s4_step_reg;
    logic [zsrl_pkg::RATE_W-1:0] s4_rate_reg;
    logic [zsrl_pkg::RATE_W-1:0] s4_rate_next;

    logic          s2_ready;
    logic          s3_ready;
    logic          s4_ready;
    logic [RW-1:0] fold1_q;
    logic [RW-1:0] fold1_r;
    logic [RW-1:0] fold2_q;
    logic [RW-1:0] fold2_r;
    logic          round_up;
    logic [QW-1:0] quot;

    assign s4_ready  = !s4_valid_reg || out_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign lvl_ready = s2_ready;

    assign out_valid      = s4_valid_reg;
    assign smoothed_value = s4_level_reg;
    assign step_used      = s4_step_reg;
    assign playback_rate  = s4_rate_reg;

    // first fold of the divide by 2^n - 1: p = q*2^n + r gives p - q*(2^n - 1) = r + q
    always_comb
    begin
        s3_quot_next = zsrl_pkg::RATE_W'(s2_prod_reg >> SAMPLE_BITS);
        s3_rem_next  = RW'(s2_prod_reg[SAMPLE_BITS-1:0]) + RW'(s3_quot_next);
    end

    // two more folds, a final correction and the minimum rate offset
    always_comb
    begin
        fold1_q      = s3_rem_reg >> SAMPLE_BITS;
        fold1_r      = RW'(s3_rem_reg[SAMPLE_BITS-1:0]) + fold1_q;
        fold2_q      = fold1_r >> SAMPLE_BITS;
        fold2_r      = RW'(fold1_r[SAMPLE_BITS-1:0]) + fold2_q;
        round_up     = fold2_r >= FULL_SCALE;
        quot         = QW'(s3_quot_reg) + QW'(fold1_q) + QW'(fold2_q) + QW'(round_up);
        s4_rate_next = zsrl_pkg::RATE_MIN + quot[zsrl_pkg::RATE_W-1:0];
    end

    always_comb
    begin
        s2_valid_next = s2_ready ? lvl_valid : s2_valid_reg;
        s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;
        s4_valid_next = s4_ready ? s3_valid_reg : s4_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && lvl_valid)
        begin
            s2_level_reg <= level;
            s2_step_reg  <= step;
            s2_prod_reg  <= PW'(level) * PW'(zsrl_pkg::RATE_SPAN);
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_level_reg <= s2_level_reg;
            s3_step_reg  <= s2_step_reg;
            s3_quot_reg  <= s3_quot_next;
            s3_rem_reg   <= s3_rem_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_level_reg <= s3_level_reg;
            s4_step_reg  <= s3_step_reg;
            s4_rate_reg  <= s4_rate_next;
        end
    end

endmodule

FILE: src/zoned_slew_rate_limiter.sv
// top level of the zoned slew rate limiter
//
//   channel   direction   handshake            payload
//   in        input       in_valid/in_ready    sample
//   out       output      out_valid/out_ready  smoothed_value, step_used, playback_rate
//   cfg       input       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained while out_ready stays high
// the smoothed level is computed combinationally and registered (one 12x10 multiply, compare, add)
// the playback rate takes three more stages: multiply, then folded divide by full scale
// every stage holds its item under a stall and frees as soon as the next stage moves
// reset clears the level to zero and loads the register defaults; cfg_ready stays high
module zoned_slew_rate_limiter
#(
    parameter int SAMPLE_BITS = zsrl_pkg::DEFAULT_SAMPLE_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [SAMPLE_BITS-1:0]            sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [SAMPLE_BITS-1:0]            smoothed_value,
    output logic [zsrl_pkg::STEP_W-1:0]       step_used,
    output logic [zsrl_pkg::RATE_W-1:0]       playback_rate,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [zsrl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [zsrl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    zsrl_pkg::cfg_t              cfg;
    logic                        lvl_valid;
    logic                        lvl_ready;
    logic [SAMPLE_BITS-1:0]      level;
    logic [zsrl_pkg::STEP_W-1:0] step;

    zsrl_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    zsrl_slew
    #(
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_slew
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .lvl_valid (lvl_valid),
        .lvl_ready (lvl_ready),
        .level     (level),
        .step      (step)
    );

    zsrl_rate
    #(
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_rate
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .lvl_valid      (lvl_valid),
        .lvl_ready      (lvl_ready),
        .level          (level),
        .step           (step),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .smoothed_value (smoothed_value),
        .step_used      (step_used),
        .playback_rate  (playback_rate)
    );

endmodule

FILE: verif/zoned_slew_rate_limiter_tb.sv
// self-checking testbench for the zoned slew rate limiter, directed table then random phases
`timescale 1ns / 100ps

module zoned_slew_rate_limiter_tb;

    localparam int SAMPLE_BITS = zsrl_pkg::DEFAULT_SAMPLE_BITS;
    localparam int unsigned FULL_SCALE = (1 << SAMPLE_BITS) - 1;
    localparam int unsigned ZONE_LOW_END = 1 << (SAMPLE_BITS - 2);
    localparam int unsigned ZONE_MID_END = 3 * ZONE_LOW_END;
    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 3;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 162;
    localparam int MAX_REPORTS = 10;

    localparam logic [zsrl_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [zsrl_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;
    typedef enum logic [1:0] { READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PERIODIC }
        ready_mode_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]        smoothed;
        logic [zsrl_pkg::STEP_W-1:0]   step_limit;
        logic [zsrl_pkg::RATE_W-1:0]   rate;
    } slew_result_t;

    typedef struct {
        row_kind_t                         kind;
        logic [zsrl_pkg::CFG_INDEX_W-1:0]  index;
        logic [zsrl_pkg::CFG_DATA_W-1:0]   value;
        bit                                checked;
        slew_result_t                      typed;
    } stim_row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic [SAMPLE_BITS-1:0]             sample;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [SAMPLE_BITS-1:0]             smoothed_value;
    logic [zsrl_pkg::STEP_W-1:0]        step_used;
    logic [zsrl_pkg::RATE_W-1:0]        playback_rate;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [zsrl_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [zsrl_pkg::CFG_DATA_W-1:0]    cfg_data;

    zsrl_pkg::cfg_t                     model_cfg;
    logic [SAMPLE_BITS-1:0]             model_level;
    slew_result_t                       pending_results[$];
    stim_row_t                          directed_rows[$];
    bit                                 directed_check;
    slew_result_t                       directed_expect;
    logic [SAMPLE_BITS-1:0]             held_target;
    ready_mode_t                        ready_mode = READY_ALWAYS;
    int                                 mode_left = 0;
    int                                 cycle_count = 0;
    int                                 failures = 0;
    int                                 results_seen = 0;

    zoned_slew_rate_limiter #(.SAMPLE_BITS(SAMPLE_BITS)) dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .smoothed_value (smoothed_value),
        .step_used      (step_used),
        .playback_rate  (playback_rate),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    function automatic slew_result_t advance_level(input logic [SAMPLE_BITS-1:0] target);
        int unsigned  lvl;
        int unsigned  limit;
        int unsigned  gap;
        bit           rising;
        slew_result_t r;
        lvl = model_level;
        if (lvl < ZONE_LOW_END)
            limit = model_cfg.low_zone_step;
        else if (lvl < ZONE_MID_END)
            limit = model_cfg.mid_zone_step;
        else
            limit = model_cfg.high_zone_step;
        rising = target > lvl;
        gap = rising ? target - lvl : lvl - target;
        if (rising)
        begin
            if (gap > model_cfg.aggressive_threshold)
                limit = (limit * model_cfg.accel_lag) >> zsrl_pkg::LAG_FRAC;
        end
        else
        begin
            limit = (limit * model_cfg.decel_lag) >> zsrl_pkg::LAG_FRAC;
        end
        if (gap > limit)
            lvl = rising ? lvl + limit : lvl - limit;
        else
            lvl = target;
        r.smoothed = SAMPLE_BITS'(lvl);
        r.step_limit = zsrl_pkg::STEP_W'(limit);
        r.rate = zsrl_pkg::RATE_W'(zsrl_pkg::RATE_MIN + (lvl * zsrl_pkg::RATE_SPAN) / FULL_SCALE);
        return r;
    endfunction

    function automatic void apply_register(input logic [zsrl_pkg::CFG_INDEX_W-1:0] idx,
                                           input logic [zsrl_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            zsrl_pkg::CFG_LOW_ZONE_STEP:
                model_cfg.low_zone_step = data[zsrl_pkg::ZONE_STEP_W-1:0];
            zsrl_pkg::CFG_MID_ZONE_STEP:
                model_cfg.mid_zone_step = data[zsrl_pkg::ZONE_STEP_W-1:0];
            zsrl_pkg::CFG_HIGH_ZONE_STEP:
                model_cfg.high_zone_step = data[zsrl_pkg::ZONE_STEP_W-1:0];
            zsrl_pkg::CFG_ACCEL_LAG:
                model_cfg.accel_lag = data[zsrl_pkg::LAG_W-1:0];
            zsrl_pkg::CFG_DECEL_LAG:
                model_cfg.decel_lag = data[zsrl_pkg::LAG_W-1:0];
            zsrl_pkg::CFG_AGGR_THRESHOLD:
                model_cfg.aggressive_threshold = data[zsrl_pkg::THRESH_W-1:0];
            default:
                ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input slew_result_t want,
                                   input slew_result_t got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%s at result %0d: expected level/step/rate %0d/%0d/%0d, got %0d/%0d/%0d",
                     what, results_seen, want.smoothed, want.step_limit, want.rate,
                     got.smoothed, got.step_limit, got.rate);
    endtask

    // model update and result check, all on the pre-edge values
    always @(posedge clk)
    begin : scoreboard
        slew_result_t predicted;
        slew_result_t seen;
        slew_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                predicted = advance_level(sample);
                model_level = predicted.smoothed;
                pending_results.push_back(directed_check ? directed_expect : predicted);
            end
            if (out_valid && out_ready)
            begin
                seen.smoothed = smoothed_value;
                seen.step_limit = step_used;
                seen.rate = playback_rate;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("item with nothing outstanding", '0, seen);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (seen.smoothed !== want.smoothed || seen.step_limit !== want.step_limit
                        || seen.rate !== want.rate)
                        report_mismatch("mismatch", want, seen);
                end
            end
        end
        else
        begin
            model_level = '0;
            model_cfg.low_zone_step = zsrl_pkg::ZONE_STEP_RESET;
            model_cfg.mid_zone_step = zsrl_pkg::ZONE_STEP_RESET;
            model_cfg.high_zone_step = zsrl_pkg::ZONE_STEP_RESET;
            model_cfg.accel_lag = zsrl_pkg::LAG_RESET;
            model_cfg.decel_lag = zsrl_pkg::LAG_RESET;
            model_cfg.aggressive_threshold = zsrl_pkg::THRESH_RESET;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stall pattern, independent of the sender
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 200);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS:   out_ready <= 1'b1;
            READY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
            READY_RARELY:   out_ready <= ($urandom_range(0, 3) == 0);
            default:        out_ready <= ((cycle_count % 7) < 2);
        endcase
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        in_valid <= 1'b1;
        sample <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [zsrl_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [zsrl_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_row(input logic [zsrl_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [zsrl_pkg::CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.kind = ROW_CFG;
        row.index = idx;
        row.value = data;
        row.checked = 1'b0;
        row.typed = '0;
        directed_rows.push_back(row);
    endtask

    task automatic item_row(input logic [SAMPLE_BITS-1:0] value, input bit checked,
                            input int lvl, input int limit, input int rate);
        stim_row_t row;
        row.kind = ROW_ITEM;
        row.index = '0;
        row.value = value;
        row.checked = checked;
        row.typed.smoothed = SAMPLE_BITS'(lvl);
        row.typed.step_limit = zsrl_pkg::STEP_W'(limit);
        row.typed.rate = zsrl_pkg::RATE_W'(rate);
        directed_rows.push_back(row);
    endtask

    function automatic logic [zsrl_pkg::CFG_DATA_W-1:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return zsrl_pkg::CFG_DATA_W'($urandom_range(1, 64));
            3:       return zsrl_pkg::CFG_DATA_W'(256);
            default: return zsrl_pkg::CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] next_sample();
        int near;
        case ($urandom_range(0, 9))
            0, 1:    return SAMPLE_BITS'($urandom);
            2:       return $urandom_range(0, 1) ? SAMPLE_BITS'(FULL_SCALE) : '0;
            3:
            begin
                case ($urandom_range(0, 3))
                    0:       return SAMPLE_BITS'(ZONE_LOW_END - 1);
                    1:       return SAMPLE_BITS'(ZONE_LOW_END);
                    2:       return SAMPLE_BITS'(ZONE_MID_END - 1);
                    default: return SAMPLE_BITS'(ZONE_MID_END);
                endcase
            end
            7, 8:
            begin
                near = int'(model_level) + $urandom_range(0, 80) - 40;
                if (near < 0)
                    near = 0;
                if (near > int'(FULL_SCALE))
                    near = FULL_SCALE;
                return SAMPLE_BITS'(near);
            end
            9:
            begin
                held_target = SAMPLE_BITS'($urandom);
                return held_target;
            end
            default: return held_target;
        endcase
    endfunction

    initial
    begin : stimulus
        int burst_left;
        int gap;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = zsrl_pkg::CFG_LOW_ZONE_STEP;
        cfg_data = '0;
        directed_check = 1'b0;
        directed_expect = '0;
        held_target = '0;

        // after reset, then full steps with top lags and zero threshold
        item_row(12'd0, 1'b1, 0, 200, 8000);
        cfg_row(zsrl_pkg::CFG_LOW_ZONE_STEP, 12'hFFF);
        cfg_row(zsrl_pkg::CFG_MID_ZONE_STEP, 12'hFFF);
        cfg_row(zsrl_pkg::CFG_HIGH_ZONE_STEP, 12'hFFF);
        cfg_row(zsrl_pkg::CFG_ACCEL_LAG, 12'hFFF);
        cfg_row(zsrl_pkg::CFG_DECEL_LAG, 12'hFFF);
        cfg_row(zsrl_pkg::CFG_AGGR_THRESHOLD, 12'h000);
        item_row(12'hFFF, 1'b1, 4095, 16364, 44100);
        item_row(12'h000, 1'b1, 0, 16364, 8000);
        // writes past the last register do nothing
        cfg_row(CFG_SPARE_A, 12'h000);
        cfg_row(CFG_SPARE_B, 12'hFFF);
        // zero lags with upper data bits set, threshold at max
        cfg_row(zsrl_pkg::CFG_ACCEL_LAG, 12'h400);
        cfg_row(zsrl_pkg::CFG_DECEL_LAG, 12'hC00);
        cfg_row(zsrl_pkg::CFG_AGGR_THRESHOLD, 12'hFFF);
        item_row(12'hFFF, 1'b1, 4095, 4095, 44100);
        item_row(12'hFFE, 1'b1, 4095, 0, 44100);
        item_row(12'hFFF, 1'b1, 4095, 0, 44100);
        // distinct zone steps to walk the zone bounds
        cfg_row(zsrl_pkg::CFG_LOW_ZONE_STEP, 12'd4000);
        cfg_row(zsrl_pkg::CFG_MID_ZONE_STEP, 12'd4001);
        cfg_row(zsrl_pkg::CFG_HIGH_ZONE_STEP, 12'd4002);
        cfg_row(zsrl_pkg::CFG_ACCEL_LAG, 12'd256);
        cfg_row(zsrl_pkg::CFG_DECEL_LAG, 12'd256);
        cfg_row(zsrl_pkg::CFG_AGGR_THRESHOLD, 12'd0);
        item_row(SAMPLE_BITS'(ZONE_LOW_END - 1), 1'b0, 0, 0, 0);
        item_row(SAMPLE_BITS'(ZONE_LOW_END), 1'b0, 0, 0, 0);
        item_row(SAMPLE_BITS'(ZONE_MID_END - 1), 1'b0, 0, 0, 0);
        item_row(SAMPLE_BITS'(ZONE_MID_END), 1'b0, 0, 0, 0);
        item_row(SAMPLE_BITS'(ZONE_MID_END), 1'b0, 0, 0, 0);
        // small steps, small rise versus sudden rise
        cfg_row(zsrl_pkg::CFG_LOW_ZONE_STEP, 12'd1);
        cfg_row(zsrl_pkg::CFG_MID_ZONE_STEP, 12'd2);
        cfg_row(zsrl_pkg::CFG_HIGH_ZONE_STEP, 12'd3);
        cfg_row(zsrl_pkg::CFG_ACCEL_LAG, 12'd512);
        cfg_row(zsrl_pkg::CFG_DECEL_LAG, 12'd128);
        cfg_row(zsrl_pkg::CFG_AGGR_THRESHOLD, 12'd100);
        item_row(12'hAAA, 1'b0, 0, 0, 0);
        item_row(12'h555, 1'b0, 0, 0, 0);
        item_row(12'd3071, 1'b0, 0, 0, 0);
        item_row(12'hFFF, 1'b0, 0, 0, 0);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                in_valid <= 1'b0;
                wait_idle();
                cfg_write(directed_rows[i].index, directed_rows[i].value);
            end
            else
            begin
                cfg_valid <= 1'b0;
                directed_check = directed_rows[i].checked;
                directed_expect = directed_rows[i].typed;
                send_sample(directed_rows[i].value);
            end
        end
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        directed_check = 1'b0;
        held_target = model_level;

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_idle();
            cfg_write(zsrl_pkg::CFG_LOW_ZONE_STEP, pick_reg_value());
            cfg_write(zsrl_pkg::CFG_MID_ZONE_STEP, pick_reg_value());
            cfg_write(zsrl_pkg::CFG_HIGH_ZONE_STEP, pick_reg_value());
            cfg_write(zsrl_pkg::CFG_ACCEL_LAG, pick_reg_value());
            cfg_write(zsrl_pkg::CFG_DECEL_LAG, pick_reg_value());
            cfg_write(zsrl_pkg::CFG_AGGR_THRESHOLD, pick_reg_value());
            if ($urandom_range(0, 2) == 0)
                cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          zsrl_pkg::CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap > 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap) @(negedge clk);
                    end
                end
                send_sample(next_sample());
                burst_left--;
            end
            in_valid <= 1'b0;
            @(negedge clk);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
